### hw/rtl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// shared types for the word-serial montgomery multiplier
// ----------------------------------------------------------------------------
package mwm_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OUTER_RD,
        S_PRE_MUL,
        S_Q_ADD,
        S_Q_MUL,
        S_INNER_RD,
        S_MUL1,
        S_ACC1,
        S_ACC2,
        S_TOP,
        S_OUT_RD,
        S_OUT_EMIT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PRE_MUL,
        DP_Q_ADD,
        DP_Q_MUL,
        DP_MUL1,
        DP_ACC1,
        DP_ACC2,
        DP_TOP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   first;
        logic   wr_prev;
    } dp_cmd_t;

endpackage

### hw/rtl/montgomery_multiply_words.sv
// ----------------------------------------------------------------------------
// montgomery_multiply_words
// word-serial cios montgomery multiplier, 32-bit words
// ----------------------------------------------------------------------------
// channel   handshake                  payload
// input     start & !busy              a_word, b_word, mod_word, last_in
// result    result_valid (one cycle)   result_word, last_out
// config    apb write, pready high     pwdata -> m_prime at paddr 0-3
//
// the load beat that carries last_in starts the operation.
// an operation runs the outer and inner steps, each inner step an operand
// read, two registered multiplies and two accumulates, then reads the result
// out, each result beat preceded by a read state.
// busy is high from the last_in beat's acceptance to the last result beat.
// reset is asynchronous, active low; results cannot be stalled.
// ----------------------------------------------------------------------------
module montgomery_multiply_words import mwm_pkg::*; #(
    parameter int NUM_WORDS = 33
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] a_word,
    input  logic [WORD_W-1:0] b_word,
    input  logic [WORD_W-1:0] mod_word,
    input  logic              last_in,
    output logic              result_valid,
    output logic [WORD_W-1:0] result_word,
    output logic              last_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IW = $clog2(NUM_WORDS);

    logic [WORD_W-1:0] m_prime_reg;
    dp_cmd_t           cmd;
    logic [IW-1:0]     idx_a, idx_b;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_prime_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            m_prime_reg <= pwdata;
        end
    end

    assign prdata = reg_sel ? m_prime_reg : '0;

    mwm_ctrl #(.NUM_WORDS(NUM_WORDS)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_in      (last_in),
        .busy         (busy),
        .result_valid (result_valid),
        .last_out     (last_out),
        .cmd          (cmd),
        .idx_a        (idx_a),
        .idx_b        (idx_b)
    );

    mwm_datapath #(.NUM_WORDS(NUM_WORDS)) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .idx_a    (idx_a),
        .idx_b    (idx_b),
        .m_prime  (m_prime_reg),
        .a_word   (a_word),
        .b_word   (b_word),
        .mod_word (mod_word),
        .sum_word (result_word)
    );

endmodule

### hw/rtl/mwm_ram.sv
// ----------------------------------------------------------------------------
// mwm_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/mwm_datapath.sv
// ----------------------------------------------------------------------------
// mwm_datapath
// operand stores, partial sum store and the two multiply-accumulate chains
// ----------------------------------------------------------------------------
module mwm_datapath import mwm_pkg::*; #(
    parameter int NUM_WORDS = 33
) (
    input  logic                         clk,
    input  dp_cmd_t                      cmd,
    input  logic [$clog2(NUM_WORDS)-1:0] idx_a,
    input  logic [$clog2(NUM_WORDS)-1:0] idx_b,
    input  logic [WORD_W-1:0]            m_prime,
    input  logic [WORD_W-1:0]            a_word,
    input  logic [WORD_W-1:0]            b_word,
    input  logic [WORD_W-1:0]            mod_word,
    output logic [WORD_W-1:0]            sum_word
);

    localparam int IW = $clog2(NUM_WORDS);

    logic [WORD_W-1:0]   a_q, b_q, m_q, s_q;
    logic                load_we, s_we;
    logic [IW-1:0]       s_waddr;
    logic [WORD_W-1:0]   s_wdata;

    logic [WORD_W-1:0]   ai_reg, t_reg, q_reg, mw_reg, sv_reg, z_reg;
    logic [2*WORD_W-1:0] prod_reg, p1_reg, p2_reg;
    logic [WORD_W-1:0]   hi1_reg, hi2_reg;
    logic [1:0]          cy1_reg, cy2_reg;

    logic [WORD_W+1:0]   s1, s2;
    logic [WORD_W-1:0]   top_word;

    assign load_we = (cmd.op == DP_LOAD);

    mwm_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_a_ram (
        .clk(clk), .we(load_we), .waddr(idx_a), .wdata(a_word),
        .raddr(idx_a), .rdata(a_q)
    );
    mwm_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_b_ram (
        .clk(clk), .we(load_we), .waddr(idx_a), .wdata(b_word),
        .raddr(idx_b), .rdata(b_q)
    );
    mwm_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_m_ram (
        .clk(clk), .we(load_we), .waddr(idx_a), .wdata(mod_word),
        .raddr(idx_b), .rdata(m_q)
    );
    mwm_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_s_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(idx_b), .rdata(s_q)
    );

    assign s1 = {2'b00, p1_reg[WORD_W-1:0]} + {2'b00, sv_reg} + {2'b00, hi1_reg}
              + {{WORD_W{1'b0}}, cy1_reg};
    assign s2 = {2'b00, z_reg} + {2'b00, p2_reg[WORD_W-1:0]} + {2'b00, hi2_reg}
              + {{WORD_W{1'b0}}, cy2_reg};
    assign top_word = hi1_reg + hi2_reg + {{(WORD_W-2){1'b0}}, cy1_reg}
                    + {{(WORD_W-2){1'b0}}, cy2_reg};

    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = IW'(NUM_WORDS - 1);
        s_wdata = top_word;
        case (cmd.op)
            DP_ACC2:
            begin
                // sum shifts down one word as it is written back
                s_we    = cmd.wr_prev;
                s_waddr = idx_b - IW'(1);
                s_wdata = s2[WORD_W-1:0];
            end
            DP_TOP:
            begin
                s_we = 1'b1;
            end
            default:
            begin
                s_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_PRE_MUL:
            begin
                ai_reg   <= a_q;
                prod_reg <= a_q * b_q;
                sv_reg   <= cmd.first ? '0 : s_q;
            end
            DP_Q_ADD:
            begin
                t_reg <= prod_reg[WORD_W-1:0] + sv_reg;
            end
            DP_Q_MUL:
            begin
                q_reg   <= WORD_W'(t_reg * m_prime);
                hi1_reg <= '0;
                hi2_reg <= '0;
                cy1_reg <= '0;
                cy2_reg <= '0;
            end
            DP_MUL1:
            begin
                p1_reg <= ai_reg * b_q;
                mw_reg <= m_q;
                // first outer step sees a cleared partial sum
                sv_reg <= cmd.first ? '0 : s_q;
            end
            DP_ACC1:
            begin
                z_reg   <= s1[WORD_W-1:0];
                cy1_reg <= s1[WORD_W+1:WORD_W];
                hi1_reg <= p1_reg[2*WORD_W-1:WORD_W];
                p2_reg  <= q_reg * mw_reg;
            end
            DP_ACC2:
            begin
                cy2_reg <= s2[WORD_W+1:WORD_W];
                hi2_reg <= p2_reg[2*WORD_W-1:WORD_W];
            end
            default:
            begin
            end
        endcase
    end

    assign sum_word = s_q;

endmodule

### hw/rtl/mwm_ctrl.sv
// ----------------------------------------------------------------------------
// mwm_ctrl
// sequencer for load, outer and inner steps and result readout
// ----------------------------------------------------------------------------
module mwm_ctrl import mwm_pkg::*; #(
    parameter int NUM_WORDS = 33
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         last_in,
    output logic                         busy,
    output logic                         result_valid,
    output logic                         last_out,
    output dp_cmd_t                      cmd,
    output logic [$clog2(NUM_WORDS)-1:0] idx_a,
    output logic [$clog2(NUM_WORDS)-1:0] idx_b
);

    localparam int IW = $clog2(NUM_WORDS);
    localparam int LW = $clog2(NUM_WORDS + 1);

    state_t        state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [LW-1:0] load_count_reg, load_count_next;
    logic          first_reg, first_next;
    logic          accept;
    logic          j_last, i_last;

    assign accept = start && (state_reg == S_IDLE);
    assign j_last = (j_reg == IW'(NUM_WORDS - 1));
    assign i_last = (i_reg == IW'(NUM_WORDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            load_count_reg <= '0;
            first_reg      <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            load_count_reg <= load_count_next;
            first_reg      <= first_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        load_count_next = load_count_reg;
        first_next      = first_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (load_count_reg < LW'(NUM_WORDS))
                    begin
                        load_count_next = load_count_reg + LW'(1);
                    end
                    if (last_in)
                    begin
                        load_count_next = '0;
                        state_next      = S_OUTER_RD;
                        i_next          = '0;
                        j_next          = '0;
                        first_next      = 1'b1;
                    end
                end
            end
            S_OUTER_RD: state_next = S_PRE_MUL;
            S_PRE_MUL:  state_next = S_Q_ADD;
            S_Q_ADD:    state_next = S_Q_MUL;
            S_Q_MUL:    state_next = S_INNER_RD;
            S_INNER_RD: state_next = S_MUL1;
            S_MUL1:     state_next = S_ACC1;
            S_ACC1:     state_next = S_ACC2;
            S_ACC2:
            begin
                if (j_last)
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_INNER_RD;
                end
            end
            S_TOP:
            begin
                j_next     = '0;
                first_next = 1'b0;
                if (i_last)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_OUTER_RD;
                end
            end
            S_OUT_RD:   state_next = S_OUT_EMIT;
            S_OUT_EMIT:
            begin
                if (j_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_OUT_RD;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.first   = first_reg;
        cmd.wr_prev = (j_reg != '0);
        cmd.op      = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (load_count_reg < LW'(NUM_WORDS)))
                begin
                    cmd.op = DP_LOAD;
                end
            end
            S_PRE_MUL: cmd.op = DP_PRE_MUL;
            S_Q_ADD:   cmd.op = DP_Q_ADD;
            S_Q_MUL:   cmd.op = DP_Q_MUL;
            S_MUL1:    cmd.op = DP_MUL1;
            S_ACC1:    cmd.op = DP_ACC1;
            S_ACC2:    cmd.op = DP_ACC2;
            S_TOP:     cmd.op = DP_TOP;
            default:   cmd.op = DP_NOP;
        endcase
    end

    assign idx_a        = (state_reg == S_IDLE) ? load_count_reg[IW-1:0] : i_reg;
    assign idx_b        = j_reg;
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT_EMIT);
    assign last_out     = result_valid && j_last;

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_count_reg <= LW'(NUM_WORDS))
        else $error("load count past operand length");

    a_inner_loop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC2 |=> state_reg == S_INNER_RD || state_reg == S_TOP)
        else $error("inner step left its loop");

    a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUTER_RD && i_reg != '0 |-> !first_reg)
        else $error("cleared sum used past first outer step");

    a_out_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_out |=> state_reg == S_IDLE)
        else $error("readout continued past last beat");

endmodule
